// ===== src/atan2_pkg.sv =====
// Package: payload types, constants and helpers for the fixed-point atan2 pipeline.
package atan2_pkg;

  typedef struct packed {
    logic signed [31:0] y_coord;
    logic signed [31:0] x_coord;
  } atan2_in_t;

  typedef struct packed {
    logic signed [18:0] angle;
    logic               undefined;
  } atan2_out_t;

  localparam int unsigned DivSteps = 33;
  localparam int unsigned PolyTerms = 5;

  localparam logic signed [18:0] AngPi     = 19'sh3243F;
  localparam logic signed [18:0] AngHalfPi = 19'sh1921F;

  localparam logic signed [17:0] Coef [PolyTerms] = '{
    18'sh0EB7, -18'sh1F0A, 18'sh3215, -18'sh553F, 18'sh10000
  };
  localparam logic signed [17:0] CoefTop = -18'sh0373;

  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic       swap;
    logic       zero;
    logic [30:0] lo;
  } atan2_side_t;

  function automatic logic [30:0] mag_sat(input logic signed [31:0] v);
    logic [31:0] n;
    begin
      n = 32'(-v);
      if (!v[31]) mag_sat = v[30:0];
      else if (n[31]) mag_sat = 31'h7FFFFFFF;
      else mag_sat = n[30:0];
    end
  endfunction

  function automatic logic signed [18:0] qmul(input logic signed [18:0] a,
                                              input logic signed [18:0] b);
    logic signed [37:0] p;
    begin
      p = a * b;
      qmul = 19'(p >>> 16);
    end
  endfunction

endpackage

// ===== src/fixed_point_atan2.sv =====
// Top level: fully pipelined four-quadrant arctangent; angle in signed Q2.16 radians.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------
//  in       | in_valid_i/in_ready_o | in_data_i  (atan2_in_t)
//  out      | out_valid_o/out_ready_i | out_data_o (atan2_out_t)
//
// One item enters per cycle whenever the pipeline advances; the stages are 1 prep, 33 divider
// stages, 10 product/polynomial/fold stages and 1 output register.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
module fixed_point_atan2 import atan2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  atan2_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output atan2_out_t out_data_o
);

  logic        en;
  logic        pre_vld_q;
  logic [30:0] hi_q;
  atan2_side_t side_q;
  logic        div_vld;
  logic [32:0] quot;
  atan2_side_t div_side;
  logic        poly_vld;
  atan2_out_t  poly_res;
  logic        out_vld_q;
  atan2_out_t  out_q;

  logic [30:0] ay;
  logic [30:0] ax;
  logic        swap;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign ay   = mag_sat(in_data_i.y_coord);
  assign ax   = mag_sat(in_data_i.x_coord);
  assign swap = ay > ax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en) begin
      pre_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hi_q         <= swap ? ay : ax;
      side_q.lo    <= swap ? ax : ay;
      side_q.swap  <= swap;
      side_q.neg_x <= in_data_i.x_coord[31];
      side_q.neg_y <= in_data_i.y_coord[31];
      side_q.zero  <= (ax == '0) && (ay == '0);
    end
  end

  atan2_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_vld_q),
    .hi_i    (hi_q),
    .side_i  (side_q),
    .valid_o (div_vld),
    .quot_o  (quot),
    .side_o  (div_side)
  );

  atan2_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .quot_i  (quot),
    .side_i  (div_side),
    .valid_o (poly_vld),
    .res_o   (poly_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= poly_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= poly_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed under stall");

  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.undefined |-> out_data_o.angle == '0)
    else $error("undefined item carries nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.angle <= AngPi) && (out_data_o.angle >= -AngPi))
    else $error("angle outside range");

endmodule

// ===== src/atan2_div.sv =====
// Pipelined restoring divider: 2^32 / hi, one quotient bit per stage, with side data.
module atan2_div import atan2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] hi_i,
  input  atan2_side_t side_i,
  output logic        valid_o,
  output logic [32:0] quot_o,
  output atan2_side_t side_o
);

  logic        vld_q  [DivSteps];
  logic [31:0] rem_q  [DivSteps];
  logic [32:0] quo_q  [DivSteps];
  logic [30:0] div_q  [DivSteps];
  atan2_side_t side_q [DivSteps];

  logic        vld_in  [DivSteps];
  logic [31:0] rem_in  [DivSteps];
  logic [32:0] quo_in  [DivSteps];
  logic [30:0] div_in  [DivSteps];
  atan2_side_t side_in [DivSteps];
  logic [32:0] trial   [DivSteps];
  logic [32:0] diff    [DivSteps];

  always_comb begin
    for (int i = 0; i < DivSteps; i++) begin
      if (i == 0) begin
        vld_in[i]  = valid_i;
        rem_in[i]  = '0;
        quo_in[i]  = '0;
        div_in[i]  = hi_i;
        side_in[i] = side_i;
      end else begin
        vld_in[i]  = vld_q[i-1];
        rem_in[i]  = rem_q[i-1];
        quo_in[i]  = quo_q[i-1];
        div_in[i]  = div_q[i-1];
        side_in[i] = side_q[i-1];
      end
      trial[i] = {rem_in[i], (i == 0) ? 1'b1 : 1'b0};
      diff[i]  = trial[i] - {2'b0, div_in[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivSteps; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < DivSteps; i++) vld_q[i] <= vld_in[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DivSteps; i++) begin
        div_q[i]  <= div_in[i];
        side_q[i] <= side_in[i];
        if (!diff[i][32]) begin
          rem_q[i] <= diff[i][31:0];
          quo_q[i] <= {quo_in[i][31:0], 1'b1};
        end else begin
          rem_q[i] <= trial[i][31:0];
          quo_q[i] <= {quo_in[i][31:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quot_o  = quo_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];

endmodule

// ===== src/atan2_poly.sv =====
// Ratio multiply, Horner polynomial stages and octant fold, at most one multiply per stage.
module atan2_poly import atan2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [32:0] quot_i,
  input  atan2_side_t side_i,
  output logic        valid_o,
  output atan2_out_t  res_o
);

  localparam int unsigned NumSt = PolyTerms + 5;

  logic              vld_q  [NumSt];
  atan2_side_t       side_q [NumSt];
  logic signed [18:0] r_q   [NumSt];
  logic signed [18:0] r2_q  [NumSt];
  logic signed [18:0] p_q   [NumSt];
  logic [63:0]       prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSt; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NumSt; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  logic [63:0] lo_prod;
  assign lo_prod = {33'b0, side_i.lo} * {31'b0, quot_i};

  logic signed [18:0] fold_a;
  logic signed [18:0] fold_b;
  logic signed [18:0] fold_c;

  always_comb begin
    fold_a = p_q[NumSt-2];
    if (side_q[NumSt-2].swap) fold_a = AngHalfPi - fold_a;
    fold_b = side_q[NumSt-2].neg_x ? AngPi - fold_a : fold_a;
    fold_c = side_q[NumSt-2].neg_y ? -fold_b : fold_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= lo_prod;
      side_q[0] <= side_i;
      r_q[0]    <= '0;
      r2_q[0]   <= '0;
      p_q[0]    <= '0;
      side_q[1] <= side_q[0];
      r_q[1]    <= 19'(prod_q >> 16);
      r2_q[1]   <= '0;
      p_q[1]    <= CoefTop;
      side_q[2] <= side_q[1];
      r_q[2]    <= r_q[1];
      r2_q[2]   <= qmul(r_q[1], r_q[1]);
      p_q[2]    <= p_q[1];
      for (int i = 3; i < NumSt - 2; i++) begin
        side_q[i] <= side_q[i-1];
        r_q[i]    <= r_q[i-1];
        r2_q[i]   <= r2_q[i-1];
        p_q[i]    <= qmul(p_q[i-1], r2_q[i-1]) + Coef[i-3];
      end
      side_q[NumSt-2] <= side_q[NumSt-3];
      r_q[NumSt-2]    <= r_q[NumSt-3];
      r2_q[NumSt-2]   <= r2_q[NumSt-3];
      p_q[NumSt-2]    <= qmul(r_q[NumSt-3], p_q[NumSt-3]);
      side_q[NumSt-1] <= side_q[NumSt-2];
      r_q[NumSt-1]    <= r_q[NumSt-2];
      r2_q[NumSt-1]   <= r2_q[NumSt-2];
      p_q[NumSt-1]    <= side_q[NumSt-2].zero ? '0 : fold_c;
    end
  end

  assign valid_o         = vld_q[NumSt-1];
  assign res_o.angle     = p_q[NumSt-1];
  assign res_o.undefined = side_q[NumSt-1].zero;

endmodule
